// File: rtl/tpi_pkg.sv
// ----------------------------------------------------------------------------
// Three-plane intersection package
// Shared constants and types for the plane solver and its divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

    // Width of one coordinate of the result point (signed Q23.8).
    localparam int QUOT_WIDTH = 32;

    // Clamp magnitudes for positive and negative coordinates.
    localparam logic [QUOT_WIDTH-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [QUOT_WIDTH-1:0] NEG_LIMIT = 32'h8000_0000;

    // Control bits that travel alongside one coordinate through the divider.
    typedef struct packed {
        logic vld;
        logic neg;
        logic sing;
    } t_div_tag;

endpackage

`default_nettype wire

// File: rtl/tpi_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Computes round(num * 2^FRAC / det) on magnitudes, one quotient bit per stage,
// and flags quotients that do not fit in the result width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_div #(
    parameter int NUM_WIDTH = 59,
    parameter int DET_WIDTH = 51,
    parameter int FRAC      = 14
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire tpi_pkg::t_div_tag           i_tag,
    input  wire [NUM_WIDTH-1:0]              i_num_mag,
    input  wire [DET_WIDTH-1:0]              i_det_mag,
    output tpi_pkg::t_div_tag                o_tag,
    output logic [tpi_pkg::QUOT_WIDTH-1:0]   o_quot,
    output logic                             o_ovf
);

    localparam int QW   = tpi_pkg::QUOT_WIDTH;
    localparam int NBW  = NUM_WIDTH + FRAC + 2;
    localparam int DDW  = DET_WIDTH + 1;
    localparam int XW   = (NBW > DDW + QW) ? NBW : DDW + QW;

    logic [XW-1:0]  w_dividend;
    logic [DDW-1:0] w_divisor;
    logic           w_ovf;

    tpi_pkg::t_div_tag r_tag [QW+1];
    logic              r_ovf [QW+1];
    logic [QW-1:0]     r_quo [QW+1];
    logic [XW-1:0]     r_rem [QW];
    logic [DDW-1:0]    r_den [QW];

    // Dividend 2*num*2^FRAC + det over divisor 2*det rounds half away from zero.
    assign w_dividend = (XW'(i_num_mag) << (FRAC + 1)) + XW'(i_det_mag);
    assign w_divisor  = {i_det_mag, 1'b0};
    assign w_ovf      = w_dividend >= (XW'(w_divisor) << QW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= w_ovf;
            r_quo[0] <= '0;
            r_rem[0] <= w_dividend;
            r_den[0] <= w_divisor;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic [XW-1:0] w_sh;
        logic          w_take;

        assign w_sh   = XW'(r_den[k]) << B;
        assign w_take = r_rem[k] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else if (i_en) begin
                r_tag[k+1] <= r_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k+1] <= r_ovf[k];
                r_quo[k+1] <= r_quo[k] | (w_take ? (QW'(1) << B) : '0);
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_take ? (r_rem[k] - w_sh) : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_tag  = r_tag[QW];
    assign o_quot = r_quo[QW];
    assign o_ovf  = r_ovf[QW];

endmodule

`default_nettype wire

// File: rtl/three_plane_intersection.sv
// ----------------------------------------------------------------------------
// Three-plane intersection
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register keeps an item that has not been taken.
// Reset (synchronous, active low) clears only the valid bits and divider tags;
// no state survives from one item to the next.
//
// Solves n_i . p = d_i for three planes by Cramer's rule. Normals are signed
// Q1.(NORMAL_WIDTH-2) and offsets signed Q(OFFSET_WIDTH-9).8; the point is
// signed Q23.8, rounded to nearest with halves away from zero and clamped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_plane_intersection #(
    parameter int NORMAL_WIDTH = 16,
    parameter int OFFSET_WIDTH = 24
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Input item, lowest bit up: plane1_nx, plane1_ny, plane1_nz, plane1_offset,
    // then the same four fields for plane 2 and plane 3, zero padded to bytes.
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [((3*(3*NORMAL_WIDTH+OFFSET_WIDTH)+7)/8)*8-1:0] i_s_tdata,
    // Result item, lowest bit up: point_x, point_y, point_z, singular,
    // saturated, zero padded to bytes.
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [103:0] o_m_tdata
);

    localparam int NW    = NORMAL_WIDTH;
    localparam int OW    = OFFSET_WIDTH;
    localparam int FRAC  = NW - 2;
    localparam int PLW   = 3 * NW + OW;          // bits of one plane
    localparam int PW    = 2 * NW;               // normal product
    localparam int CW    = 2 * NW + 1;           // cross product component
    localparam int DW    = NW + CW + 2;          // determinant
    localparam int MW    = OW + CW + 2;          // numerator
    localparam int QW    = tpi_pkg::QUOT_WIDTH;
    localparam int OUT_W = 104;

    // The whole pipeline moves together; it stalls only on a held result.
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Unpack the three planes.
    logic signed [NW-1:0] w_n [3][3];
    logic signed [OW-1:0] w_d [3];

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        for (genvar k = 0; k < 3; k++) begin : g_axis
            assign w_n[i][k] = i_s_tdata[i*PLW + k*NW +: NW];
        end
        assign w_d[i] = i_s_tdata[i*PLW + 3*NW +: OW];
    end

    // Stage valid bits for the stages ahead of the dividers.
    logic r_vld [1:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 5; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_s_tvalid;
            for (int s = 2; s <= 5; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1: the eighteen normal products of the three cross products.
    // Cross j pairs planes (j+1) and (j+2) modulo 3, so cross 0 is n2 x n3,
    // cross 1 is n3 x n1 and cross 2 is n1 x n2.
    logic signed [PW-1:0] r1_pp [3][3][2];
    logic signed [NW-1:0] r1_n1 [3];
    logic signed [OW-1:0] r1_d  [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_pp[j][k][0] <= w_n[(j+1)%3][(k+1)%3] * w_n[(j+2)%3][(k+2)%3];
                    r1_pp[j][k][1] <= w_n[(j+1)%3][(k+2)%3] * w_n[(j+2)%3][(k+1)%3];
                end
                r1_n1[j] <= w_n[0][j];
                r1_d[j]  <= w_d[j];
            end
        end
    end

    // Stage 2: cross product components.
    logic signed [CW-1:0] r2_c  [3][3];
    logic signed [NW-1:0] r2_n1 [3];
    logic signed [OW-1:0] r2_d  [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_c[j][k] <= CW'(r1_pp[j][k][0]) - CW'(r1_pp[j][k][1]);
                end
                r2_n1[j] <= r1_n1[j];
                r2_d[j]  <= r1_d[j];
            end
        end
    end

    // Stage 3: determinant terms n1 . (n2 x n3) and numerator terms d_j * c_j.
    logic signed [NW+CW-1:0] r3_dt [3];
    logic signed [OW+CW-1:0] r3_nt [3][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_dt[k] <= r2_n1[k] * r2_c[0][k];
                for (int j = 0; j < 3; j++) begin
                    r3_nt[j][k] <= r2_d[j] * r2_c[j][k];
                end
            end
        end
    end

    // Stage 4: sums.
    logic signed [DW-1:0] r4_det;
    logic signed [MW-1:0] r4_num [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_det <= DW'(r3_dt[0]) + DW'(r3_dt[1]) + DW'(r3_dt[2]);
            for (int k = 0; k < 3; k++) begin
                r4_num[k] <= MW'(r3_nt[0][k]) + MW'(r3_nt[1][k]) + MW'(r3_nt[2][k]);
            end
        end
    end

    // Stage 5: magnitudes, quotient signs and the singular test.
    logic [DW-1:0] r5_dmag;
    logic [MW-1:0] r5_nmag [3];
    logic          r5_neg  [3];
    logic          r5_sing;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_dmag <= r4_det[DW-1] ? DW'(-r4_det) : DW'(r4_det);
            r5_sing <= r4_det == '0;
            for (int k = 0; k < 3; k++) begin
                r5_nmag[k] <= r4_num[k][MW-1] ? MW'(-r4_num[k]) : MW'(r4_num[k]);
                r5_neg[k]  <= r4_num[k][MW-1] ^ r4_det[DW-1];
            end
        end
    end

    // Stages 6 to 38: one divider per coordinate, one quotient bit a stage.
    tpi_pkg::t_div_tag w_tag_in  [3];
    tpi_pkg::t_div_tag w_tag_out [3];
    logic [QW-1:0]     w_quot    [3];
    logic              w_ovf     [3];
    logic [QW-1:0]     w_coord   [3];
    logic              w_clamp   [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        assign w_tag_in[k] = '{vld: r_vld[5], neg: r5_neg[k], sing: r5_sing};

        tpi_div #(
            .NUM_WIDTH (MW),
            .DET_WIDTH (DW),
            .FRAC      (FRAC)
        ) u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_tag     (w_tag_in[k]),
            .i_num_mag (r5_nmag[k]),
            .i_det_mag (r5_dmag),
            .o_tag     (w_tag_out[k]),
            .o_quot    (w_quot[k]),
            .o_ovf     (w_ovf[k])
        );

        // Clamp, apply the sign, and force zero on a singular system.
        logic [QW-1:0] w_limit;
        logic [QW-1:0] w_mag;

        assign w_limit    = w_tag_out[k].neg ? tpi_pkg::NEG_LIMIT : tpi_pkg::POS_LIMIT;
        assign w_clamp[k] = !w_tag_out[k].sing && (w_ovf[k] || (w_quot[k] > w_limit));
        assign w_mag      = w_clamp[k] ? w_limit : w_quot[k];
        assign w_coord[k] = w_tag_out[k].sing ? '0 :
                            (w_tag_out[k].neg ? (QW'(0) - w_mag) : w_mag);
    end

    // Output register.
    logic          r_out_vld;
    logic [QW-1:0] r_pt [3];
    logic          r_sing;
    logic          r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_tag_out[0].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pt[k] <= w_coord[k];
            end
            r_sing <= w_tag_out[0].sing;
            r_sat  <= w_clamp[0] || w_clamp[1] || w_clamp[2];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(OUT_W - 3*QW - 2)'(0), r_sat, r_sing, r_pt[2], r_pt[1], r_pt[0]};

endmodule

`default_nettype wire
